>>> hdl/ppsdm_pkg.sv
// ----------------------------------------------------------------------------
// PPS-to-UTC delay meter: shared types and constants
// Status codes, register indexes and the reciprocal constants that turn the
// divisions by 100 and 1000 into multiplications.
// ----------------------------------------------------------------------------
package ppsdm_pkg;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_NO_PPS   = 2'd1,
		STATUS_TOO_LONG = 2'd2
	} status_t;

	localparam logic REG_SAMPLES_PER_TENTH = 1'b0;
	localparam logic REG_MAX_DELAY         = 1'b1;

	localparam int CFG_WIDTH    = 16;
	localparam int UTC_WIDTH    = 27;
	localparam int TENTHS_WIDTH = 20;
	localparam int SEC_WIDTH    = 17;
	localparam int DIGIT_WIDTH  = 4;
	localparam int SCALE_WIDTH  = DIGIT_WIDTH + CFG_WIDTH;
	localparam int DELAY_WIDTH  = 32;

	localparam logic [UTC_WIDTH-1:0] UTC_MS_MAX = 27'd86399999;
	localparam logic [UTC_WIDTH:0]   ROUND_HALF = 28'd50;

	// floor(x / 100) = (x * RECIP_100) >> 34 and floor(x / 1000) =
	// (x * RECIP_1000) >> 37 hold exactly for every x below 2^27.
	localparam int                  RECIP_WIDTH = 28;
	localparam logic [RECIP_WIDTH-1:0] RECIP_100  = 28'd171798692;
	localparam int                  SHIFT_100   = 34;
	localparam logic [RECIP_WIDTH-1:0] RECIP_1000 = 28'd137438954;
	localparam int                  SHIFT_1000  = 37;

	localparam logic [CFG_WIDTH-1:0]   SPT_RESET   = 16'd50;
	localparam logic [CFG_WIDTH-1:0]   MAX_RESET   = 16'd300;
	localparam logic [DELAY_WIDTH-1:0] DELAY_RESET = 32'd50;

endpackage

>>> hdl/pps_to_utc_delay_meter.sv
// ----------------------------------------------------------------------------
// PPS-to-UTC delay meter
// Measures, in samples, how far the latched PPS edge lies from the UTC second
// that the receiver reports, and holds the result between tenths changes.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one sample per beat: the thresholded PPS level and
// the receiver's UTC time of day in milliseconds. The master stream returns
// one beat per sample with a status code and the held delay in samples
// (zero unless the status says the delay is valid). The configuration port
// sets the samples per tenth of a second and the largest valid delay; write
// it only while no beat is in flight.
// Throughput is one beat per cycle unless the receiver stalls: the tenths
// rounding is one stage of reciprocal multipliers, the tenths digit scaling a
// second, and the state update with the delay subtraction a third, which is
// also the output stage. When the receiver stalls, the whole pipeline holds
// and s_tready falls.
// Reset clears the sample counter and edge history, sets the status to "no
// PPS yet" with a held delay of 50, and loads the register defaults.
// ----------------------------------------------------------------------------
module pps_to_utc_delay_meter #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [0] pps_high, [27:1] utc_ms, [31:28] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [1:0] status, [33:2] delay_samples, [39:34] zero
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [ppsdm_pkg::CFG_WIDTH-1:0] cfg_wdata
);
	import ppsdm_pkg::*;

	localparam int DW = ((COUNT_WIDTH > DELAY_WIDTH) ? COUNT_WIDTH : DELAY_WIDTH) + 2;
	localparam int PW = 2 * RECIP_WIDTH;

	// Configuration registers
	logic [CFG_WIDTH-1:0] spt_q;
	logic [CFG_WIDTH-1:0] max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spt_q <= SPT_RESET;
			max_q <= MAX_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_SAMPLES_PER_TENTH: spt_q <= cfg_wdata;
				REG_MAX_DELAY:         max_q <= cfg_wdata;
				default:               ;
			endcase
		end
	end

	// Pipeline control: all stages advance together.
	logic v1_q, v2_q, out_valid_q;
	logic adv;

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = adv;
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v1_q        <= s_tvalid;
			v2_q        <= v1_q;
			out_valid_q <= v2_q;
		end
	end

	// Stage 1: clamp, round to tenths and whole seconds.
	logic [UTC_WIDTH-1:0] utc_ms;
	logic [UTC_WIDTH-1:0] ms_clamped;
	logic [UTC_WIDTH:0]   ms_rounded;
	logic [PW-1:0]        mul100, mul1000;

	assign utc_ms     = s_tdata[UTC_WIDTH:1];
	assign ms_clamped = (utc_ms > UTC_MS_MAX) ? UTC_MS_MAX : utc_ms;
	assign ms_rounded = {1'b0, ms_clamped} + ROUND_HALF;
	assign mul100     = {{(PW-UTC_WIDTH-1){1'b0}}, ms_rounded} *
	                    {{(PW-RECIP_WIDTH){1'b0}}, RECIP_100};
	assign mul1000    = {{(PW-UTC_WIDTH-1){1'b0}}, ms_rounded} *
	                    {{(PW-RECIP_WIDTH){1'b0}}, RECIP_1000};

	logic                    high_s1;
	logic [TENTHS_WIDTH-1:0] tenths_s1;
	logic [SEC_WIDTH-1:0]    sec_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			high_s1   <= s_tdata[0];
			tenths_s1 <= mul100[SHIFT_100 +: TENTHS_WIDTH];
			sec_s1    <= mul1000[SHIFT_1000 +: SEC_WIDTH];
		end
	end

	// Stage 2: tenths digit scaled to samples.
	logic [TENTHS_WIDTH-1:0] digit_full;
	logic [DIGIT_WIDTH-1:0]  digit;
	logic [SCALE_WIDTH-1:0]  scale;

	assign digit_full = tenths_s1 - {sec_s1, 3'b000} - {2'b00, sec_s1, 1'b0};
	assign digit      = digit_full[DIGIT_WIDTH-1:0];
	assign scale      = {{CFG_WIDTH{1'b0}}, digit} * {{DIGIT_WIDTH{1'b0}}, spt_q};

	logic                    high_s2;
	logic [TENTHS_WIDTH-1:0] tenths_s2;
	logic [SEC_WIDTH-1:0]    sec_s2;
	logic [SCALE_WIDTH-1:0]  scale_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			high_s2   <= high_s1;
			tenths_s2 <= tenths_s1;
			sec_s2    <= sec_s1;
			scale_s2  <= scale;
		end
	end

	// Stage 3: edge tracking, latch on a whole-second step, held result.
	logic [COUNT_WIDTH-1:0]  sample_index_q;
	logic                    started_high_q, pulse_high_q;
	logic                    pend_valid_q, lat_valid_q;
	logic [COUNT_WIDTH-1:0]  pend_index_q, lat_index_q;
	logic [TENTHS_WIDTH-1:0] last_tenths_q;
	logic [SEC_WIDTH-1:0]    last_sec_q;
	status_t                 held_status_q;
	logic signed [DELAY_WIDTH-1:0] held_delay_q;

	logic                    first, step;
	logic                    nxt_started, nxt_pulse, nxt_pend_valid, nxt_lat_valid;
	logic [COUNT_WIDTH-1:0]  nxt_pend_index, nxt_lat_index, elapsed;
	logic signed [DW-1:0]    diff;
	logic signed [DELAY_WIDTH-1:0] diff_sat, nxt_delay;
	status_t                 nxt_status;

	localparam logic signed [DW-1:0] SAT_HI = {{(DW-DELAY_WIDTH){1'b0}}, 32'h7FFF_FFFF};
	localparam logic signed [DW-1:0] SAT_LO = {{(DW-DELAY_WIDTH){1'b1}}, 32'h8000_0000};

	always_comb begin
		first          = (sample_index_q == '0);
		nxt_started    = started_high_q;
		nxt_pulse      = pulse_high_q;
		nxt_pend_valid = pend_valid_q;
		nxt_pend_index = pend_index_q;
		if (high_s2) begin
			if (first) begin
				nxt_started = 1'b1;
			end else if (!pulse_high_q && !started_high_q) begin
				nxt_pulse      = 1'b1;
				nxt_pend_valid = 1'b1;
				nxt_pend_index = sample_index_q;
			end
		end else begin
			nxt_pulse   = 1'b0;
			nxt_started = 1'b0;
		end

		// The first sample only seeds the tenths history.
		step          = !first && (tenths_s2 != last_tenths_q);
		nxt_lat_valid = lat_valid_q;
		nxt_lat_index = lat_index_q;
		if (step && (sec_s2 > last_sec_q)) begin
			nxt_lat_valid = nxt_pend_valid;
			nxt_lat_index = nxt_pend_index;
		end

		elapsed  = sample_index_q - nxt_lat_index;
		diff     = $signed({{(DW-COUNT_WIDTH){1'b0}}, elapsed}) -
		           $signed({{(DW-SCALE_WIDTH){1'b0}}, scale_s2});
		if (diff > SAT_HI)
			diff_sat = SAT_HI[DELAY_WIDTH-1:0];
		else if (diff < SAT_LO)
			diff_sat = SAT_LO[DELAY_WIDTH-1:0];
		else
			diff_sat = diff[DELAY_WIDTH-1:0];

		nxt_delay  = step ? diff_sat : held_delay_q;
		nxt_status = step ? STATUS_OK : held_status_q;
		if (!nxt_lat_valid)
			nxt_status = STATUS_NO_PPS;
		if ((nxt_status == STATUS_OK) &&
		    (nxt_delay > $signed({{(DELAY_WIDTH-CFG_WIDTH){1'b0}}, max_q})))
			nxt_status = STATUS_TOO_LONG;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_index_q <= '0;
			started_high_q <= 1'b0;
			pulse_high_q   <= 1'b0;
			pend_valid_q   <= 1'b0;
			pend_index_q   <= '0;
			lat_valid_q    <= 1'b0;
			lat_index_q    <= '0;
			last_tenths_q  <= '0;
			last_sec_q     <= '0;
			held_status_q  <= STATUS_NO_PPS;
			held_delay_q   <= DELAY_RESET;
		end else if (adv && v2_q) begin
			sample_index_q <= sample_index_q + COUNT_WIDTH'(1);
			started_high_q <= nxt_started;
			pulse_high_q   <= nxt_pulse;
			pend_valid_q   <= nxt_pend_valid;
			pend_index_q   <= nxt_pend_index;
			lat_valid_q    <= nxt_lat_valid;
			lat_index_q    <= nxt_lat_index;
			// Equal to the old value whenever no tenths change is seen.
			last_tenths_q  <= tenths_s2;
			last_sec_q     <= sec_s2;
			held_status_q  <= nxt_status;
			held_delay_q   <= nxt_delay;
		end
	end

	assign m_tdata = {6'd0,
	                  (held_status_q == STATUS_OK) ? held_delay_q : {DELAY_WIDTH{1'b0}},
	                  held_status_q};

	// Assertions
	a_ok_needs_edge: assert property (@(posedge clk) disable iff (!arst_n)
		held_status_q == STATUS_OK |-> lat_valid_q)
		else $error("delay reported valid without a latched PPS edge");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |=> $stable(held_delay_q) && $stable(held_status_q))
		else $error("held result changed while the output beat was stalled");

	a_pending_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(pend_valid_q) && !$fell(lat_valid_q))
		else $error("edge valid flag cleared after being set");

	a_count_on_beat: assert property (@(posedge clk) disable iff (!arst_n)
		sample_index_q != $past(sample_index_q) |-> $past(adv && v2_q))
		else $error("sample counter moved without a beat leaving stage two");

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// Testbench for the PPS-to-UTC delay meter
// Streams samples of PPS level and UTC milliseconds into the block and checks
// result beats against a cycle-free model of the edge tracking, tenths
// rounding and delay arithmetic. A short list of hand-picked samples comes
// first, then simulated receiver time with PPS pulses near each second, mixed
// with noise, under several register settings and handshake idling patterns.
// ----------------------------------------------------------------------------
module tb;
	import ppsdm_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int PHASE_ITEMS = 90;
	localparam int DAY_MS      = 86400000;
	localparam longint DELAY_HI = 64'sd2147483647;
	localparam longint DELAY_LO = -64'sd2147483648;

	typedef struct packed {
		status_t     status;
		logic [31:0] delay;
	} meter_result_t;

	typedef struct packed {
		logic        pps;
		logic [26:0] utc;
		logic        typed;
		status_t     status;
		logic [31:0] delay;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [31:0]          s_tdata;   // [0] pps_high, [27:1] utc_ms, [31:28] zero
	logic                 m_tvalid;
	logic                 m_tready;
	logic [39:0]          m_tdata;   // [1:0] status, [33:2] delay_samples, [39:34] zero
	logic                 cfg_we;
	logic                 cfg_addr;
	logic [CFG_WIDTH-1:0] cfg_wdata;

	// Model state of the meter
	logic [31:0] mdl_count;
	logic [31:0] mdl_pend_idx;
	logic [31:0] mdl_latch_idx;
	bit          mdl_started_high;
	bit          mdl_pulse_high;
	bit          mdl_pend_valid;
	bit          mdl_latch_valid;
	int unsigned mdl_last_tenths;
	status_t     mdl_status;
	longint      mdl_delay;
	logic [15:0] mdl_spt;
	logic [15:0] mdl_max;

	meter_result_t delay_results_due[$];

	int errors = 0;
	int stall_cycles = 0;
	int samples_sent = 0;
	int n_ok = 0;
	int n_no_pps = 0;
	int n_too_long = 0;
	int n_settings = 0;
	int tx_idle_pct = 31;
	int rx_idle_pct = 75;

	// Simulated receiver: clock in ms, ms per sample, PPS lead and width
	int unsigned rx_ms;
	int unsigned rx_step;
	int unsigned rx_lead;
	int unsigned rx_pulse;

	// Expected results are typed in only for the opening rows after reset; those beats are checked against them.
	stim_row_t dir_rows[18] = '{
		'{1'b1, 27'd0,         1'b1, STATUS_NO_PPS, 32'd0},
		'{1'b1, 27'd49,        1'b1, STATUS_NO_PPS, 32'd0},
		'{1'b0, 27'd50,        1'b1, STATUS_NO_PPS, 32'd0},
		'{1'b1, 27'd120,       1'b1, STATUS_NO_PPS, 32'd0},
		'{1'b1, 27'd950,       1'b1, STATUS_OK,     32'd1},
		'{1'b0, 27'd1049,      1'b0, STATUS_OK,     32'd0},
		'{1'b0, 27'd1050,      1'b0, STATUS_OK,     32'd0},
		'{1'b1, 27'd1950,      1'b0, STATUS_OK,     32'd0},
		'{1'b0, 27'd500,       1'b0, STATUS_OK,     32'd0},
		'{1'b0, 27'h7FFFFFF,   1'b0, STATUS_OK,     32'd0},
		'{1'b1, 27'd86399999,  1'b0, STATUS_OK,     32'd0},
		'{1'b0, 27'd0,         1'b0, STATUS_OK,     32'd0},
		'{1'b1, 27'd100,       1'b0, STATUS_OK,     32'd0},
		'{1'b1, 27'd1000,      1'b0, STATUS_OK,     32'd0},
		'{1'b0, 27'd86400000,  1'b0, STATUS_OK,     32'd0},
		'{1'b0, 27'd1000,      1'b0, STATUS_OK,     32'd0},
		'{1'b0, 27'd1549,      1'b0, STATUS_OK,     32'd0},
		'{1'b0, 27'd1550,      1'b0, STATUS_OK,     32'd0}
	};

	pps_to_utc_delay_meter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic reset_meter_model();
		mdl_count        = '0;
		mdl_pend_idx     = '0;
		mdl_latch_idx    = '0;
		mdl_started_high = 1'b0;
		mdl_pulse_high   = 1'b0;
		mdl_pend_valid   = 1'b0;
		mdl_latch_valid  = 1'b0;
		mdl_last_tenths  = 0;
		mdl_status       = STATUS_NO_PPS;
		mdl_delay        = 50;
		mdl_spt          = SPT_RESET;
		mdl_max          = MAX_RESET;
	endtask

	// Advances the model by one sample and returns the held status and delay.
	task automatic predict_held_delay(input logic pps, input logic [26:0] utc,
			output meter_result_t res);
		int unsigned ms;
		int unsigned tenths;
		longint      jump;
		longint      d;
		logic [31:0] elapsed;
		bit          first_sample;
		first_sample = (mdl_count == 0);
		ms = (utc > UTC_MS_MAX) ? UTC_MS_MAX : utc;
		tenths = (ms + 50) / 100;

		if (pps) begin
			if (first_sample) begin
				mdl_started_high = 1'b1;
			end else if (!mdl_pulse_high && !mdl_started_high) begin
				mdl_pulse_high = 1'b1;
				mdl_pend_idx   = mdl_count;
				mdl_pend_valid = 1'b1;
			end
		end else begin
			mdl_pulse_high   = 1'b0;
			mdl_started_high = 1'b0;
		end

		if (first_sample)
			mdl_last_tenths = tenths;

		if (tenths != mdl_last_tenths) begin
			// Only a move into a later whole second takes over the pending edge.
			jump = longint'(tenths) - 10 * longint'(mdl_last_tenths / 10);
			if (jump >= 10) begin
				mdl_latch_idx   = mdl_pend_idx;
				mdl_latch_valid = mdl_pend_valid;
			end
			elapsed = mdl_count - mdl_latch_idx;
			d = longint'(elapsed) - longint'(tenths % 10) * longint'(mdl_spt);
			if (d > DELAY_HI)
				d = DELAY_HI;
			if (d < DELAY_LO)
				d = DELAY_LO;
			mdl_delay       = d;
			mdl_status      = STATUS_OK;
			mdl_last_tenths = tenths;
		end

		if (!mdl_latch_valid)
			mdl_status = STATUS_NO_PPS;
		if (mdl_status == STATUS_OK && mdl_delay > longint'(mdl_max))
			mdl_status = STATUS_TOO_LONG;
		mdl_count = mdl_count + 1;

		res.status = mdl_status;
		res.delay  = (mdl_status == STATUS_OK) ? mdl_delay[31:0] : '0;
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("ERROR: %s: got 0x%0h, expected 0x%0h", what, got, want);
		errors++;
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_sample(input logic pps, input logic [26:0] utc,
			input logic typed, input meter_result_t typed_res);
		meter_result_t res;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {4'b0, utc, pps};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_held_delay(pps, utc, res);
		delay_results_due.push_back(typed ? typed_res : res);
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic send_random_sample();
		logic          pps;
		logic [26:0]   utc;
		meter_result_t unused;
		unused = '0;
		if ($urandom_range(99) < 15) begin
			pps = 1'($urandom_range(1));
			utc = ($urandom_range(1) == 1) ? 27'($urandom) : 27'($urandom_range(86399999));
		end else begin
			// Now and then run the receiver clock up to midnight.
			if ($urandom_range(99) < 2)
				rx_ms = DAY_MS - 20 * rx_step;
			rx_ms += rx_step + (($urandom_range(19) == 0) ? $urandom_range(rx_step) : 0);
			if (rx_ms >= DAY_MS)
				rx_ms -= DAY_MS;
			pps = (((rx_ms + rx_lead) % 1000) < rx_pulse);
			utc = 27'(rx_ms);
		end
		send_sample(pps, utc, 1'b0, unused);
	endtask

	task automatic write_reg(input logic addr, input logic [CFG_WIDTH-1:0] value);
		cfg_we    = 1'b1;
		cfg_addr  = addr;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		if (addr == REG_SAMPLES_PER_TENTH)
			mdl_spt = value;
		else
			mdl_max = value;
	endtask

	// The sender holds off until every result is back, then the registers change.
	task automatic start_setting(input logic [15:0] spt, input logic [15:0] delay_limit,
			input int tx_pct, input int rx_pct);
		s_tvalid = 1'b0;
		while (delay_results_due.size() != 0)
			@(negedge clk);
		write_reg(REG_SAMPLES_PER_TENTH, spt);
		write_reg(REG_MAX_DELAY, delay_limit);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		rx_step  = (spt == 0) ? 20 : ((spt > 100) ? 1 : 100 / spt);
		rx_lead  = $urandom_range(300);
		rx_pulse = 3 * rx_step + $urandom_range(50);
		rx_ms    = $urandom_range(86390) * 1000 + 5000 - 40 * rx_step;
		n_settings++;
		repeat (PHASE_ITEMS)
			send_random_sample();
	endtask

	always @(negedge clk)
		m_tready = ($urandom_range(99) >= rx_idle_pct);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	always @(posedge clk) begin : result_check
		meter_result_t want;
		if (m_tvalid && m_tready) begin
			if (delay_results_due.size() == 0) begin
				report_mismatch("result beat with nothing outstanding", m_tdata[33:2], '0);
			end else begin
				want = delay_results_due.pop_front();
				if (m_tdata[1:0] != want.status)
					report_mismatch("status", 32'(m_tdata[1:0]), 32'(want.status));
				if (m_tdata[33:2] != want.delay)
					report_mismatch("delay_samples", m_tdata[33:2], want.delay);
				case (want.status)
					STATUS_OK:     n_ok++;
					STATUS_NO_PPS: n_no_pps++;
					default:       n_too_long++;
				endcase
			end
		end
	end

	initial begin
		do
			@(posedge clk);
		while (stall_cycles < STALL_LIMIT);
		$display("Timed out with %0d results outstanding", delay_results_due.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		meter_result_t row_res;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		cfg_we    = 1'b0;
		cfg_addr  = REG_SAMPLES_PER_TENTH;
		cfg_wdata = '0;
		reset_meter_model();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			row_res.status = dir_rows[i].status;
			row_res.delay  = dir_rows[i].delay;
			send_sample(dir_rows[i].pps, dir_rows[i].utc, dir_rows[i].typed, row_res);
		end

		start_setting(16'd5, 16'd20, 31, 75);
		start_setting(16'd1, 16'd0, 31, 75);
		start_setting(16'd65535, 16'd65535, 75, 31);
		start_setting(16'd0, 16'd65535, 75, 31);
		start_setting(16'($urandom_range(20, 1)), 16'($urandom_range(200)), 0, 0);
		start_setting(16'd4, 16'd65535, 0, 0);

		s_tvalid = 1'b0;
		while (delay_results_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d samples under the reset defaults and %0d register settings.",
			samples_sent, n_settings);
		$display("Results: %0d valid delays, %0d before any PPS edge, %0d beyond the limit.",
			n_ok, n_no_pps, n_too_long);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
